FILE: hdl/buddy_block_allocator_top_macros.svh
// assertion macros for the buddy block allocator top level
// needs clk and rst_n in the scope where they are used
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// consequent must hold in the same cycle
`define BBA_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the next cycle
`define BBA_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bba_pkg.sv
// shared types for the buddy block allocator
// status codes, datapath commands and status flags; no dependencies
`default_nettype none

package bba_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SIZE  = 2'd1,
    ST_NO_FIT    = 2'd2,
    ST_NO_HANDLE = 2'd3
  } st_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_SCAN_A,
    DP_SCAN_F,
    DP_RELEASE,
    DP_SCAN_B,
    DP_MERGE,
    DP_SPLIT,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    st_t    code;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free_op;
    logic bad_size;
    logic handle_ok;
    logic scan_done;
    logic found;
    logic need_split;
    logic splits_ok;
    logic whole;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hdl/bba_req_if.sv
// request channel of the buddy block allocator
// valid/ready handshake with the request fields; no dependencies
`default_nettype none

interface bba_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  request_size;
  logic [6:0]  handle_offset;
  logic [31:0] handle_generation;
  logic        handle_valid;

  modport source (output valid, opcode, request_size, handle_offset,
                  handle_generation, handle_valid, input ready);
  modport sink (input valid, opcode, request_size, handle_offset,
                handle_generation, handle_valid, output ready);
endinterface

`default_nettype wire

FILE: hdl/bba_rsp_if.sv
// result channel of the buddy block allocator
// valid/ready handshake with the result fields; no dependencies
`default_nettype none

interface bba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [6:0]  block_offset;
  logic [7:0]  grant_units;
  logic [31:0] grant_generation;

  modport source (output valid, status, block_offset, grant_units, grant_generation,
                  input ready);
  modport sink (input valid, status, block_offset, grant_units, grant_generation,
                output ready);
endinterface

`default_nettype wire

FILE: hdl/bba_ctrl.sv
// sequencer of the buddy block allocator
// steps the datapath through scans, splits and merges; uses bba_pkg
`default_nettype none

module bba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bba_pkg::dp_stat_t stat,
  output bba_pkg::dp_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_A,
    S_FIT_A,
    S_SPLIT,
    S_SCAN_F,
    S_FOUND_F,
    S_MERGE_CHK,
    S_SCAN_B,
    S_BUDDY,
    S_FINISH
  } state_t;

  state_t          state_r, state_nxt;
  bba_pkg::st_t    code_r, code_nxt;

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd.op    = bba_pkg::DP_NOP;
    cmd.code  = code_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = bba_pkg::DP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_free_op) begin
          if (stat.handle_ok) begin
            state_nxt = S_SCAN_F;
          end else begin
            code_nxt  = bba_pkg::ST_NO_HANDLE;
            state_nxt = S_FINISH;
          end
        end else if (stat.bad_size) begin
          code_nxt  = bba_pkg::ST_BAD_SIZE;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_SCAN_A;
        end
      end
      S_SCAN_A: begin
        cmd.op = bba_pkg::DP_SCAN_A;
        if (stat.scan_done) state_nxt = S_FIT_A;
      end
      S_FIT_A: begin
        if (!stat.found || !stat.splits_ok) begin
          code_nxt  = bba_pkg::ST_NO_FIT;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (stat.need_split) begin
          cmd.op = bba_pkg::DP_SPLIT;
        end else begin
          code_nxt  = bba_pkg::ST_OK;
          state_nxt = S_FINISH;
        end
      end
      S_SCAN_F: begin
        cmd.op = bba_pkg::DP_SCAN_F;
        if (stat.scan_done) state_nxt = S_FOUND_F;
      end
      S_FOUND_F: begin
        if (stat.found) begin
          cmd.op    = bba_pkg::DP_RELEASE;
          state_nxt = S_MERGE_CHK;
        end else begin
          code_nxt  = bba_pkg::ST_NO_HANDLE;
          state_nxt = S_FINISH;
        end
      end
      S_MERGE_CHK: begin
        if (stat.whole) begin
          code_nxt  = bba_pkg::ST_OK;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_SCAN_B;
        end
      end
      S_SCAN_B: begin
        cmd.op = bba_pkg::DP_SCAN_B;
        if (stat.scan_done) state_nxt = S_BUDDY;
      end
      S_BUDDY: begin
        if (stat.found) begin
          cmd.op    = bba_pkg::DP_MERGE;
          state_nxt = S_MERGE_CHK;
        end else begin
          code_nxt  = bba_pkg::ST_OK;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the result register has room
        if (!stat.out_busy) begin
          cmd.op    = bba_pkg::DP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= bba_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bba_dp.sv
// datapath of the buddy block allocator: block table, scan index, result register
// driven by commands from bba_ctrl; uses bba_pkg
`default_nettype none

module bba_dp #(
  parameter int ARENA_UNITS     = 128,
  parameter int MIN_BLOCK_UNITS = 8,
  parameter int TABLE_SLOTS     = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bba_pkg::dp_cmd_t cmd,
  output bba_pkg::dp_stat_t  stat,
  input  wire logic          in_opcode,
  input  wire logic [7:0]    in_request_size,
  input  wire logic [6:0]    in_handle_offset,
  input  wire logic [31:0]   in_handle_generation,
  input  wire logic          in_handle_valid,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         out_status,
  output logic [6:0]         out_block_offset,
  output logic [7:0]         out_grant_units,
  output logic [31:0]        out_grant_generation
);

  localparam int MAXU = (ARENA_UNITS > MIN_BLOCK_UNITS) ? ARENA_UNITS : MIN_BLOCK_UNITS;
  localparam int OW   = $clog2(ARENA_UNITS);
  localparam int SW   = $clog2(MAXU) + 2;
  localparam int LW   = $clog2(SW);
  localparam int IW   = (TABLE_SLOTS > 2) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW   = $clog2(TABLE_SLOTS + 1);

  function automatic logic [LW-1:0] lg2(input logic [SW-1:0] v);
    logic [LW-1:0] r;
    r = '0;
    for (int k = 0; k < SW; k++) begin
      if (v[k]) r = LW'(k);
    end
    return r;
  endfunction

  logic [OW-1:0] off_r [TABLE_SLOTS];
  logic [SW-1:0] sz_r  [TABLE_SLOTS];
  logic          fr_r  [TABLE_SLOTS];
  logic [31:0]   gn_r  [TABLE_SLOTS];

  logic [CW-1:0] count_r, idx_r;
  logic [IW-1:0] pick_r, bi_r, keep, drop;
  logic          found_r, opc_r, bad_r, hval_r;
  logic [SW-1:0] pick_sz_r, need_r, need_nxt, half;
  logic [OW-1:0] pick_off_r, buddy_off;
  logic [6:0]    hoff_r;
  logic [31:0]   hgen_r, stamp_r, stamp_g;
  logic          need_set;

  logic [OW-1:0] e_off;
  logic [SW-1:0] e_sz;
  logic          e_fr;
  logic [31:0]   e_gn;

  assign e_off = off_r[idx_r[IW-1:0]];
  assign e_sz  = sz_r[idx_r[IW-1:0]];
  assign e_fr  = fr_r[idx_r[IW-1:0]];
  assign e_gn  = gn_r[idx_r[IW-1:0]];

  // smallest minimum block times a power of two that covers the request
  always_comb begin
    need_nxt = SW'(MIN_BLOCK_UNITS);
    need_set = 1'b0;
    for (int k = 0; k < 9; k++) begin
      if (!need_set && ((SW'(MIN_BLOCK_UNITS) << k) >= SW'(in_request_size))) begin
        need_nxt = SW'(MIN_BLOCK_UNITS) << k;
        need_set = 1'b1;
      end
    end
  end

  assign half      = pick_sz_r >> 1;
  assign buddy_off = pick_off_r ^ OW'(pick_sz_r);
  assign keep      = (pick_r < bi_r) ? pick_r : bi_r;
  assign drop      = (pick_r < bi_r) ? bi_r : pick_r;
  assign stamp_g   = (stamp_r == 32'd0) ? 32'd1 : stamp_r;

  always_comb begin
    stat.is_free_op = opc_r;
    stat.bad_size   = bad_r;
    stat.handle_ok  = hval_r;
    stat.scan_done  = (idx_r == count_r - CW'(1));
    stat.found      = found_r;
    stat.need_split = (pick_sz_r > need_r);
    stat.splits_ok  = (32'(count_r) + 32'(lg2(pick_sz_r)) - 32'(lg2(need_r)))
                      <= 32'(TABLE_SLOTS);
    stat.whole      = (32'(pick_sz_r) >= 32'(ARENA_UNITS));
    stat.out_busy   = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= CW'(1);
      off_r[0]  <= '0;
      sz_r[0]   <= SW'(ARENA_UNITS);
      fr_r[0]   <= 1'b1;
      gn_r[0]   <= '0;
      stamp_r   <= 32'd1;
      out_valid <= 1'b0;
      idx_r     <= '0;
      found_r   <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (cmd.op)
        bba_pkg::DP_LOAD: begin
          opc_r     <= in_opcode;
          bad_r     <= (in_request_size == 8'd0) ||
                       (32'(in_request_size) > 32'(ARENA_UNITS));
          need_r    <= need_nxt;
          hoff_r    <= in_handle_offset;
          hgen_r    <= in_handle_generation;
          hval_r    <= in_handle_valid;
          idx_r     <= '0;
          found_r   <= 1'b0;
          pick_sz_r <= '0;
        end
        bba_pkg::DP_SCAN_A: begin
          // smallest fitting free block, first one wins a tie
          if (e_fr && e_sz >= need_r && (!found_r || e_sz < pick_sz_r)) begin
            pick_r     <= idx_r[IW-1:0];
            pick_sz_r  <= e_sz;
            pick_off_r <= e_off;
            found_r    <= 1'b1;
          end
          idx_r <= idx_r + CW'(1);
        end
        bba_pkg::DP_SCAN_F: begin
          if (!found_r && !e_fr && 32'(e_off) == 32'(hoff_r) && e_gn == hgen_r) begin
            pick_r     <= idx_r[IW-1:0];
            pick_sz_r  <= e_sz;
            pick_off_r <= e_off;
            found_r    <= 1'b1;
          end
          idx_r <= idx_r + CW'(1);
        end
        bba_pkg::DP_RELEASE: begin
          fr_r[pick_r] <= 1'b1;
          gn_r[pick_r] <= '0;
          idx_r        <= '0;
          found_r      <= 1'b0;
        end
        bba_pkg::DP_SCAN_B: begin
          if (!found_r && e_fr && e_sz == pick_sz_r && e_off == buddy_off) begin
            bi_r    <= idx_r[IW-1:0];
            found_r <= 1'b1;
          end
          idx_r <= idx_r + CW'(1);
        end
        bba_pkg::DP_MERGE: begin
          // close the gap left by the higher of the pair
          for (int j = 0; j < TABLE_SLOTS - 1; j++) begin
            if (IW'(j) >= drop) begin
              off_r[j] <= off_r[j+1];
              sz_r[j]  <= sz_r[j+1];
              fr_r[j]  <= fr_r[j+1];
              gn_r[j]  <= gn_r[j+1];
            end
          end
          sz_r[keep] <= pick_sz_r << 1;
          fr_r[keep] <= 1'b1;
          gn_r[keep] <= '0;
          pick_r     <= keep;
          pick_sz_r  <= pick_sz_r << 1;
          pick_off_r <= pick_off_r & ~OW'(pick_sz_r);
          count_r    <= count_r - CW'(1);
          idx_r      <= '0;
          found_r    <= 1'b0;
        end
        bba_pkg::DP_SPLIT: begin
          // open a slot after the pick for its right half
          for (int j = 1; j < TABLE_SLOTS; j++) begin
            if (CW'(j) > CW'(pick_r) + CW'(1)) begin
              off_r[j] <= off_r[j-1];
              sz_r[j]  <= sz_r[j-1];
              fr_r[j]  <= fr_r[j-1];
              gn_r[j]  <= gn_r[j-1];
            end else if (CW'(j) == CW'(pick_r) + CW'(1)) begin
              off_r[j] <= pick_off_r + OW'(half);
              sz_r[j]  <= half;
              fr_r[j]  <= 1'b1;
              gn_r[j]  <= '0;
            end
          end
          sz_r[pick_r] <= half;
          pick_sz_r    <= half;
          count_r      <= count_r + CW'(1);
        end
        bba_pkg::DP_OUT: begin
          out_valid            <= 1'b1;
          out_status           <= cmd.code;
          out_block_offset     <= '0;
          out_grant_units      <= '0;
          out_grant_generation <= '0;
          if (cmd.code == bba_pkg::ST_OK && !opc_r) begin
            fr_r[pick_r]         <= 1'b0;
            gn_r[pick_r]         <= stamp_g;
            stamp_r              <= stamp_g + 32'd1;
            out_block_offset     <= 7'(32'(pick_off_r));
            out_grant_units      <= 8'(32'(pick_sz_r));
            out_grant_generation <= stamp_g;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/buddy_block_allocator_top.sv
// channel   dir  handshake          payload
// in_ch     in   valid/ready        opcode, request_size, handle_offset, handle_*
// out_ch    out  valid/ready        status, block_offset, grant_units, grant_generation
//
// one request at a time; a request with a bad size or handle is refused at its check
// step, an allocate scans the table for the smallest fitting free block and splits it
// down to size, a free scans for its handle, releases it and merges buddies until none is free or the arena is whole.
// the scan walks the live table entries one a cycle, a split or merge shifts the whole
// table at once, and the next request is taken the cycle after the result is issued.
// reset (rst_n low, synchronous) leaves one free block covering the whole arena.
// a result waiting on out_ch does not stop the next request being taken; that request
// then holds in its last step until the result register is free.
// top level of the buddy block allocator; uses bba_pkg, bba_req_if, bba_rsp_if,
// bba_ctrl, bba_dp and buddy_block_allocator_top_macros.svh
`default_nettype none
`include "buddy_block_allocator_top_macros.svh"

module buddy_block_allocator_top #(
  parameter int ARENA_UNITS     = 128,
  parameter int MIN_BLOCK_UNITS = 8,
  parameter int TABLE_SLOTS     = 32
) (
  input wire logic  clk,
  input wire logic  rst_n,
  bba_req_if.sink   in_ch,
  bba_rsp_if.source out_ch
);

  bba_pkg::dp_cmd_t  dp_cmd;
  bba_pkg::dp_stat_t dp_stat;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  bba_dp #(
    .ARENA_UNITS     (ARENA_UNITS),
    .MIN_BLOCK_UNITS (MIN_BLOCK_UNITS),
    .TABLE_SLOTS     (TABLE_SLOTS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (dp_cmd),
    .stat                 (dp_stat),
    .in_opcode            (in_ch.opcode),
    .in_request_size      (in_ch.request_size),
    .in_handle_offset     (in_ch.handle_offset),
    .in_handle_generation (in_ch.handle_generation),
    .in_handle_valid      (in_ch.handle_valid),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_status           (out_ch.status),
    .out_block_offset     (out_ch.block_offset),
    .out_grant_units      (out_ch.grant_units),
    .out_grant_generation (out_ch.grant_generation)
  );

  `BBA_CHECK_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "busy")
  `BBA_CHECK_NOW(a_split_needed, dp_cmd.op == bba_pkg::DP_SPLIT, dp_stat.need_split, "split")
  `BBA_CHECK_NOW(a_grant_stamped, out_ch.valid && out_ch.grant_units != 8'd0, out_ch.grant_generation != 32'd0, "stamp")
  `BBA_CHECK_NEXT(a_result_held, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.status), "held")

endmodule

`default_nettype wire
